@@ src/mts_pkg.sv @@
`timescale 1ns / 1ps

package mts_pkg;

	// Stack geometry and word widths.
	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	// Stored words carry two extra bits so that 2*value - max never overflows.
	localparam int WORD_W      = DATA_W + 2;

	// Operation codes.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Status codes reported with each result.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Shift control broadcast to every cell of the stack.
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctl_t;

endpackage

@@ src/max_tracking_stack.sv @@
`timescale 1ns / 1ps

// Channel  | Direction | Ports                                              | Handshake
// ---------+-----------+----------------------------------------------------+---------------------
// command  | in        | op, value                                          | start high, busy low
// result   | out       | status, removed_value, top_value, max_value,       | done, one cycle
//          |           | is_empty                                           |
//
// One transaction per clock cycle: busy is never raised, and the result of a
// transaction accepted at one edge is shown, marked by done, in the cycle that follows.
// The row of cells shifts all stored words together on each push or pop.
// Reset clears the element count, the maximum and the result strobe; the stored
// words are not cleared, as only written entries are ever read.
// The receiver cannot stall: each result is present for exactly one cycle.
module max_tracking_stack import mts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] removed_value,
	output logic signed [DATA_W-1:0] top_value,
	output logic signed [DATA_W-1:0] max_value,
	output logic                     is_empty
);

	logic [CNT_W-1:0]         count_q;
	logic signed [DATA_W-1:0] max_q;
	logic                     done_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] removed_q;

	logic                     accept;
	logic                     empty;
	logic                     full;
	shift_ctl_t               ctl;
	logic signed [WORD_W-1:0] cell_word [STACK_DEPTH];
	logic signed [WORD_W-1:0] top_word;
	logic signed [WORD_W-1:0] value_w;
	logic signed [WORD_W-1:0] max_w;
	logic signed [WORD_W-1:0] enc_word;
	logic signed [WORD_W-1:0] restored_max;
	logic signed [WORD_W-1:0] push_word;
	logic                     top_encoded;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(STACK_DEPTH));
	assign ctl.push = accept && (op == OP_PUSH) && !full;
	assign ctl.pop  = accept && (op == OP_POP) && !empty;

	// Encoding arithmetic on 34-bit words.
	assign top_word     = cell_word[0];
	assign value_w      = {{(WORD_W-DATA_W){value[DATA_W-1]}}, value};
	assign max_w        = {{(WORD_W-DATA_W){max_q[DATA_W-1]}}, max_q};
	assign enc_word     = {value_w[WORD_W-2:0], 1'b0} - max_w;
	assign restored_max = {max_w[WORD_W-2:0], 1'b0} - top_word;
	assign top_encoded  = (top_word > max_w);

	// A value above the current maximum of a non-empty stack is stored encoded.
	always_comb begin
		if (!empty && (value_w > max_w)) begin
			push_word = enc_word;
		end else begin
			push_word = value_w;
		end
	end

	// Row of cells, the top of the stack in cell zero.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] up_word;
		logic signed [WORD_W-1:0] down_word;

		if (i == 0) begin : g_first
			assign up_word = push_word;
		end else begin : g_mid
			assign up_word = cell_word[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign down_word = cell_word[i];
		end else begin : g_inner
			assign down_word = cell_word[i+1];
		end

		mts_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.from_up   (up_word),
			.from_down (down_word),
			.word      (cell_word[i])
		);
	end

	// Count, maximum and the registered part of the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			max_q     <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			removed_q <= '0;
		end else begin
			done_q <= accept;
			if (accept) begin
				removed_q <= '0;
				if (op == OP_PUSH) begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
						count_q  <= count_q + CNT_W'(1);
						if (empty || (value_w > max_w)) begin
							max_q <= value;
						end
					end
				end else begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						status_q <= ST_OK;
						count_q  <= count_q - CNT_W'(1);
						if (top_encoded) begin
							removed_q <= max_q;
							max_q     <= restored_max[DATA_W-1:0];
						end else begin
							removed_q <= top_word[DATA_W-1:0];
						end
					end
				end
			end
		end
	end

	// Decoded top and maximum follow the state left by the transaction.
	always_comb begin
		if (empty) begin
			top_value = '0;
			max_value = '0;
		end else begin
			max_value = max_q;
			top_value = top_encoded ? max_q : top_word[DATA_W-1:0];
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign is_empty      = empty;

endmodule

@@ src/mts_cell.sv @@
`timescale 1ns / 1ps

module mts_cell import mts_pkg::*; (
	input  logic                     clk,
	input  shift_ctl_t               ctl,
	input  logic signed [WORD_W-1:0] from_up,
	input  logic signed [WORD_W-1:0] from_down,
	output logic signed [WORD_W-1:0] word
);

	logic signed [WORD_W-1:0] word_q;

	// A push moves every word one place deeper; a pop moves every word one place up.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			word_q <= from_up;
		end else if (ctl.pop) begin
			word_q <= from_down;
		end
	end

	assign word = word_q;

endmodule

@@ src/mts_checker.sv @@
`timescale 1ns / 1ps

module mts_checker import mts_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     op,
	input logic signed [DATA_W-1:0] value,
	input logic                     done,
	input logic [1:0]               status,
	input logic signed [DATA_W-1:0] removed_value,
	input logic signed [DATA_W-1:0] top_value,
	input logic signed [DATA_W-1:0] max_value,
	input logic                     is_empty
);

	// Every accepted transaction yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted transaction gave no result");

	// No result without a transaction accepted in the cycle before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without accepted transaction");

	// An empty stack reports zero for its top and its maximum.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_empty) |-> (top_value == '0 && max_value == '0))
		else $error("empty stack reports non-zero values");

	// A pop on an empty stack removes nothing and leaves the stack empty.
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (is_empty && removed_value == '0))
		else $error("pop on empty stack reported wrongly");

	// The decoded top never exceeds the maximum.
	a_top_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_empty) |-> (top_value <= max_value))
		else $error("top exceeds maximum");

endmodule

bind max_tracking_stack mts_checker u_mts_checker (.*);
